>>> rtl/eprm_pkg.sv
// Shared types and constants for the encoder period and speed meter.
package eprm_pkg;

  localparam int SamplesDefault = 32;

  localparam int STAMP_W  = 16;
  localparam int SUM_W    = 22;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 32;
  localparam int DIV_W    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [STAMP_W-1:0] WRAP_RESET = 16'd50000;
  localparam logic [SPEED_W-1:0] NUM_RESET  = 32'd31735537;
  localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};

  // Register index, taken from the word address
  typedef enum logic [0:0] {
    REG_WRAP = 1'b0,
    REG_NUM  = 1'b1
  } cfg_reg_t;

  // Item command
  typedef enum logic [0:0] {
    CMD_CAPTURE = 1'b0,
    CMD_TICK    = 1'b1
  } item_cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_APPLY     = 6'b000010,
    ST_AVG_WAIT  = 6'b000100,
    ST_SPD_START = 6'b001000,
    ST_SPD_WAIT  = 6'b010000,
    ST_DONE      = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_item;
    logic apply;
    logic avg_start;
    logic avg_load;
    logic spd_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic blk_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/eprm_div.sv
// Restoring divider, one quotient bit per cycle.
module eprm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [eprm_pkg::DIV_W-1:0] dividend,
  input  logic [eprm_pkg::DIV_W-1:0] divisor,
  output logic [eprm_pkg::DIV_W-1:0] quotient,
  output logic                      busy
);
  import eprm_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[DIV_W]) begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

endmodule

>>> rtl/eprm_dp.sv
// Datapath: configuration, measurement state, speed divider and result register.
module eprm_dp #(
  parameter int SAMPLES_PER_AVERAGE = eprm_pkg::SamplesDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eprm_pkg::ctrl_cmd_t           cmd,
  output eprm_pkg::dp_status_t          status,
  input  logic                          in_cmd,
  input  logic [eprm_pkg::STAMP_W-1:0]  in_timestamp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eprm_pkg::CFG_AW-1:0]   paddr,
  input  logic [eprm_pkg::CFG_DW-1:0]   pwdata,
  output logic [eprm_pkg::CFG_DW-1:0]   prdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [eprm_pkg::PERIOD_W-1:0] out_avg_period,
  output logic [eprm_pkg::SPEED_W-1:0]  out_speed_q8,
  output logic                          out_average_updated
);
  import eprm_pkg::*;

  localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE);
  localparam int MUL_W  = SUM_W + 1;
  localparam int AVG_SH = SUM_W + CNT_W;
  localparam int PROD_W = SUM_W + MUL_W;
  // Rounded-up reciprocal, exact floor division for any sum of SUM_W bits
  localparam logic [MUL_W-1:0] AVG_MUL = MUL_W'(((longint'(1) << AVG_SH) +
    longint'(SAMPLES_PER_AVERAGE) - 1) / longint'(SAMPLES_PER_AVERAGE));

  logic [STAMP_W-1:0]  wrap_r;
  logic [SPEED_W-1:0]  num_r;
  logic [STAMP_W-1:0]  last_stamp_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PERIOD_W-1:0] period_r;
  logic                stop_r;
  logic                upd_r;
  item_cmd_t           cmd_r;
  logic [STAMP_W-1:0]  ts_r;
  logic [SUM_W-1:0]    avg_sum_r;

  logic                out_valid_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_upd_r;

  logic [STAMP_W-1:0]  diff;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_sat;
  logic                blk_done;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;
  logic [PROD_W-1:0]   avg_prod;
  logic [SUM_W-1:0]    avg_full;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quo;
  logic                div_busy;

  // Backward step means the timer wrapped once; correct modulo wrap_r
  always_comb begin
    if (ts_r >= last_stamp_r) begin
      diff = ts_r - last_stamp_r;
    end else begin
      diff = wrap_r + ts_r - last_stamp_r;
    end
    sum_ext  = {1'b0, sum_r} + {{(SUM_W + 1 - STAMP_W){1'b0}}, diff};
    sum_sat  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    blk_done = (cmd_r == CMD_CAPTURE) && (cnt_r == CNT_W'(SAMPLES_PER_AVERAGE - 1));
  end

  // Block average by reciprocal multiplication of the latched sum
  always_comb begin
    avg_prod = PROD_W'(avg_sum_r) * PROD_W'(AVG_MUL);
    avg_full = SUM_W'(avg_prod >> AVG_SH);
  end

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_WRAP: prdata = {{(CFG_DW - STAMP_W){1'b0}}, wrap_r};
      REG_NUM:  prdata = num_r;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= WRAP_RESET;
      num_r  <= NUM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WRAP: wrap_r <= pwdata[STAMP_W-1:0];
        REG_NUM:  num_r  <= pwdata[SPEED_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r <= item_cmd_t'(in_cmd);
      ts_r  <= in_timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_start) begin
      avg_sum_r <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      period_r     <= '0;
      stop_r       <= 1'b0;
      upd_r        <= 1'b0;
    end else if (cmd.apply) begin
      if (cmd_r == CMD_CAPTURE) begin
        last_stamp_r <= ts_r;
        if (blk_done) begin
          sum_r <= '0;
          cnt_r <= '0;
          upd_r <= 1'b1;
        end else begin
          sum_r <= sum_sat;
          cnt_r <= cnt_r + CNT_W'(1);
          upd_r <= 1'b0;
        end
      end else begin
        if (stop_r) begin
          period_r <= '0;
        end
        stop_r <= 1'b1;
        upd_r  <= 1'b0;
      end
    end else if (cmd.avg_load) begin
      // Saturate the average at the period width
      period_r <= (|avg_full[SUM_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}} : avg_full[PERIOD_W-1:0];
      stop_r   <= 1'b0;
    end
  end

  // The divider serves the speed only
  assign div_start    = cmd.spd_start;
  assign div_dividend = num_r;
  assign div_divisor  = {{(DIV_W - PERIOD_W){1'b0}}, period_r};

  eprm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_period_r <= period_r;
      out_speed_r  <= (period_r == '0) ? '0 : div_quo[SPEED_W-1:0];
      out_upd_r    <= upd_r;
    end
  end

  assign status.blk_done = blk_done;
  assign status.div_done = !div_busy;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_avg_period      = out_period_r;
  assign out_speed_q8        = out_speed_r;
  assign out_average_updated = out_upd_r;

endmodule

>>> rtl/eprm_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module eprm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eprm_pkg::dp_status_t status,
  output eprm_pkg::ctrl_cmd_t  cmd
);
  import eprm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.blk_done) begin
          cmd.avg_start = 1'b1;
          state_nxt     = ST_AVG_WAIT;
        end else begin
          state_nxt = ST_SPD_START;
        end
      end
      ST_AVG_WAIT: begin
        cmd.avg_load = 1'b1;
        state_nxt    = ST_SPD_START;
      end
      ST_SPD_START: begin
        cmd.spd_start = 1'b1;
        state_nxt     = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/encoder_period_rpm_meter.sv
// Top level of the encoder period and speed meter.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_cmd, in_timestamp
//   out_    | output    | out_valid / out_ready | out_avg_period, out_speed_q8,
//           |           |                       |   out_average_updated
//   cfg     | input     | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// An item goes from accept through the apply, speed-start, divider-wait
// (32-step speed divider) and done states; a capture that closes a block of
// samples also passes the average-wait state, for the average multiply.
// Reset is synchronous; no clearing pass, the block takes items right after.
// One item is in work at a time; the next is accepted once its predecessor's
// result sits in the output register, even while that result is stalled.
module encoder_period_rpm_meter #(
  parameter int SAMPLES_PER_AVERAGE = eprm_pkg::SamplesDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [eprm_pkg::STAMP_W-1:0]  in_timestamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eprm_pkg::PERIOD_W-1:0] out_avg_period,
  output logic [eprm_pkg::SPEED_W-1:0]  out_speed_q8,
  output logic                          out_average_updated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eprm_pkg::CFG_AW-1:0]   paddr,
  input  logic [eprm_pkg::CFG_DW-1:0]   pwdata,
  output logic [eprm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import eprm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  eprm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  eprm_dp #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_cmd              (in_cmd),
    .in_timestamp        (in_timestamp),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_avg_period      (out_avg_period),
    .out_speed_q8        (out_speed_q8),
    .out_average_updated (out_average_updated)
  );

endmodule

>>> rtl/eprm_chk.sv
// Port-level checker for the encoder period and speed meter, with its bind.
module eprm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [eprm_pkg::PERIOD_W-1:0] out_avg_period,
  input logic [eprm_pkg::SPEED_W-1:0]  out_speed_q8,
  input logic                          out_average_updated
);

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_avg_period) &&
      $stable(out_speed_q8) && $stable(out_average_updated))
    else $error("stalled result changed");

  // Zero period reports zero speed
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_avg_period == '0) |-> (out_speed_q8 == '0))
    else $error("nonzero speed at zero period");

  // Accepted item closes the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during work");

  // A fresh result only follows a cycle with the input closed
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work");

endmodule

bind encoder_period_rpm_meter eprm_chk u_eprm_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_avg_period      (out_avg_period),
  .out_speed_q8        (out_speed_q8),
  .out_average_updated (out_average_updated)
);
